@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/ssa_pkg.sv @@
// shared types and constants of the snapshot sequence assembler
`default_nettype none

package ssa_pkg;

    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned INST_W   = 32;
    localparam int unsigned CHANGE_W = 64;
    localparam int unsigned ACTION_W = 3;

    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_ACCUM        = 3'd0;
    localparam action_t ACT_SIMPLE       = 3'd1;
    localparam action_t ACT_AGGREGATED   = 3'd2;
    localparam action_t ACT_SKIPPED      = 3'd3;
    localparam action_t ACT_INCONSISTENT = 3'd4;
    localparam action_t ACT_OUT_OF_SEQ   = 3'd5;
    localparam action_t ACT_DISABLED     = 3'd6;

    // bound for a start-up jump from zero: the first sequence number must exceed it
    localparam logic [SEQ_W-1:0] INIT_JUMP_MIN = 32'd255;

endpackage

`default_nettype wire

@@ src/snapshot_sequence_assembler.sv @@
// a request is held in the input registers, its result in the result registers
// throughput: one request per cycle while the output is not stalled, the result register frees the input side
// the snapshot state is updated in the same cycle the result register loads
// reset clears the sequence and snapshot state and sets snapshots enabled
// config writes are taken in any cycle, ready is always high
`default_nettype none

module snapshot_sequence_assembler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data,
    // requests
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ssa_pkg::SEQ_W-1:0]       packet_sequence,
    input  wire logic [ssa_pkg::INST_W-1:0]      instrument_code,
    input  wire logic [ssa_pkg::CHANGE_W-1:0]    change_number,
    input  wire logic                            last_in_book,
    input  wire logic                            drop_levels,
    input  wire logic                            carries_levels,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output ssa_pkg::action_t                     action,
    output logic                                 publish,
    output logic                                 in_sequence,
    output logic [ssa_pkg::CHANGE_W-1:0]         published_change
);

    // input stage
    logic                            in_valid_reg;
    logic [ssa_pkg::SEQ_W-1:0]       seq_reg;
    logic [ssa_pkg::INST_W-1:0]      inst_reg;
    logic [ssa_pkg::CHANGE_W-1:0]    chg_reg;
    logic                            last_reg;
    logic                            drop_reg;
    logic                            has_lv_reg;

    // block state
    logic                            enabled_reg;
    logic [ssa_pkg::SEQ_W-1:0]       last_seq_reg,  last_seq_next;
    logic [ssa_pkg::INST_W-1:0]      open_inst_reg, open_inst_next;
    logic [ssa_pkg::CHANGE_W-1:0]    open_chg_reg,  open_chg_next;
    logic [ssa_pkg::INST_W-1:0]      skip_inst_reg, skip_inst_next;
    logic                            levels_reg,    levels_next;

    // result stage
    logic                            out_valid_reg;
    ssa_pkg::action_t                action_reg,    action_next;
    logic                            publish_reg,   publish_next;
    logic                            inseq_reg,     inseq_next;
    logic [ssa_pkg::CHANGE_W-1:0]    pub_chg_reg,   pub_chg_next;

    logic advance;
    logic seq_ok;
    logic ids_match;
    logic lv_now;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // sequence check
    always_comb
    begin
        if (seq_reg == last_seq_reg ||
            seq_reg == last_seq_reg + ssa_pkg::SEQ_W'(1)) begin
            seq_ok = 1'b1;
        end
        else if (seq_reg < last_seq_reg) begin
            seq_ok = (seq_reg == '0) && (last_seq_reg == '1);
        end
        else begin
            seq_ok = (seq_reg > ssa_pkg::INIT_JUMP_MIN) && (last_seq_reg == '0);
        end
    end

    assign ids_match = (inst_reg == open_inst_reg) && (chg_reg == open_chg_reg);
    assign lv_now    = !drop_reg && has_lv_reg;

    always_comb
    begin
        last_seq_next  = seq_reg;
        open_inst_next = open_inst_reg;
        open_chg_next  = open_chg_reg;
        skip_inst_next = skip_inst_reg;
        levels_next    = levels_reg;
        action_next    = ssa_pkg::ACT_ACCUM;
        publish_next   = 1'b0;
        inseq_next     = seq_ok;

        if (!seq_ok) begin
            action_next = ssa_pkg::ACT_OUT_OF_SEQ;
            if (last_reg) begin
                open_inst_next = '0;
                open_chg_next  = '0;
                skip_inst_next = '0;
                levels_next    = 1'b0;
            end
            else begin
                open_inst_next = inst_reg;
                open_chg_next  = chg_reg;
            end
        end
        else if (!enabled_reg) begin
            action_next = ssa_pkg::ACT_DISABLED;
        end
        else if (last_reg) begin
            if (open_inst_reg != '0) begin
                if (!ids_match) begin
                    action_next = ssa_pkg::ACT_INCONSISTENT;
                end
                else if (skip_inst_reg == '0) begin
                    action_next  = ssa_pkg::ACT_AGGREGATED;
                    publish_next = !drop_reg && (levels_reg || lv_now);
                end
                else begin
                    action_next = ssa_pkg::ACT_SKIPPED;
                end
            end
            else begin
                action_next  = ssa_pkg::ACT_SIMPLE;
                publish_next = !drop_reg && (levels_reg || lv_now);
            end
            open_inst_next = '0;
            open_chg_next  = '0;
            skip_inst_next = '0;
            levels_next    = 1'b0;
        end
        else begin
            levels_next = levels_reg || lv_now;
            if (open_inst_reg != '0) begin
                // first mismatch inside an open snapshot marks it as skipped
                if (skip_inst_reg == '0 && !ids_match) begin
                    skip_inst_next = inst_reg;
                    action_next    = ssa_pkg::ACT_INCONSISTENT;
                end
            end
            else begin
                open_inst_next = inst_reg;
                open_chg_next  = chg_reg;
            end
        end

        pub_chg_next = publish_next ? chg_reg : '0;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            seq_reg    <= packet_sequence;
            inst_reg   <= instrument_code;
            chg_reg    <= change_number;
            last_reg   <= last_in_book;
            drop_reg   <= drop_levels;
            has_lv_reg <= carries_levels;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            action_reg  <= action_next;
            publish_reg <= publish_next;
            inseq_reg   <= inseq_next;
            pub_chg_reg <= pub_chg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enabled_reg   <= 1'b1;
            last_seq_reg  <= '0;
            open_inst_reg <= '0;
            open_chg_reg  <= '0;
            skip_inst_reg <= '0;
            levels_reg    <= 1'b0;
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                enabled_reg <= cfg_data;
            end
            if (advance) begin
                last_seq_reg  <= last_seq_next;
                open_inst_reg <= open_inst_next;
                open_chg_reg  <= open_chg_next;
                skip_inst_reg <= skip_inst_next;
                levels_reg    <= levels_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign action           = action_reg;
    assign publish          = publish_reg;
    assign in_sequence      = inseq_reg;
    assign published_change = pub_chg_reg;

endmodule

`default_nettype wire

@@ src/ssa_checker.sv @@
// port-level checks of the snapshot sequence assembler, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ssa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire ssa_pkg::action_t              action,
    input wire logic                          publish,
    input wire logic                          in_sequence,
    input wire logic [ssa_pkg::CHANGE_W-1:0]  published_change
);

    // a stalled result keeps its contents
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action) && $stable(published_change))

    // only simple or aggregated completions publish
    `ASSERT_IMPL(a_pub_kind, clk, rst_n, out_valid && publish, action == ssa_pkg::ACT_SIMPLE || action == ssa_pkg::ACT_AGGREGATED)

    // change id is shown only when publishing
    `ASSERT_IMPL(a_pub_change, clk, rst_n, out_valid && !publish, published_change == '0)

    // out of sequence action goes with a failed check and nothing else
    `ASSERT_IMPL(a_seq_action, clk, rst_n, out_valid, in_sequence == (action != ssa_pkg::ACT_OUT_OF_SEQ))

endmodule

bind snapshot_sequence_assembler ssa_checker u_ssa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .publish          (publish),
    .in_sequence      (in_sequence),
    .published_change (published_change)
);

`default_nettype wire
